// File: rtl/hpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, constants and helpers for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  // Fixed-point format of matrix entries and coordinates
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

  // Configuration register file
  localparam int CFG_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // Accumulator: three 64-bit products plus translation, never overflows
  localparam int ACC_W = 66;

  // Divider: quotient bits retired per pipeline stage
  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = (32 + FRAC_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int NUM_W      = DIV_STAGES * STEP_BITS;

  typedef enum logic {
    CMD_POINT = 1'b0,
    CMD_DIR   = 1'b1
  } cmd_t;

  // One restoring-division lane: partial remainder, shifting dividend, quotient
  typedef struct packed {
    logic [31:0]      rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } lane_t;

  // Payload of one divider pipeline stage
  typedef struct packed {
    logic             div;
    logic             sat;
    logic [2:0]       neg;
    logic [31:0]      den;
    lane_t [2:0]      lane;
    logic [2:0][31:0] res;
  } dstg_t;

  // Truncate toward zero by FRAC_BITS and clamp to signed 32 bits.
  // Returns {saturated, value}.
  function automatic logic [32:0] reduce_acc(input logic signed [ACC_W-1:0] a);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    logic             sat;
    logic [31:0]      val;
    neg = a[ACC_W-1];
    mag = neg ? (~a + ACC_W'(1)) : a;
    q   = mag >> FRAC_BITS;
    if (!neg) begin
      sat = q > ACC_W'(32'h7FFF_FFFF);
      val = sat ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat = q > ACC_W'(32'h8000_0000);
      val = sat ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return {sat, val};
  endfunction

endpackage

// File: rtl/hpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_if
// Valid/ready channels of the homogeneous point transform.
// ----------------------------------------------------------------------------
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;
  modport source (output valid, command, x_in, y_in, z_in, input ready);
  modport sink (input valid, command, x_in, y_in, z_in, output ready);
endinterface

interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic [31:0] z_out;
  logic        divided;
  logic        saturated;
  modport source (output valid, x_out, y_out, z_out, divided, saturated, input ready);
  modport sink (input valid, x_out, y_out, z_out, divided, saturated, output ready);
endinterface

interface hpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hpt_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_div_step
// Restoring division step: retires STEP_BITS quotient bits of one lane.
// ----------------------------------------------------------------------------
module hpt_div_step
  import hpt_pkg::*;
(
  input  lane_t       lane_i,
  input  logic [31:0] den_i,
  output lane_t       lane_o
);

  // Shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    logic [31:0]      rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [32:0]      sh;
    rem = lane_i.rem;
    num = lane_i.num;
    quo = lane_i.quo;
    for (int b = 0; b < STEP_BITS; b++) begin
      sh  = {rem, num[NUM_W-1]};
      num = num << 1;
      if (sh >= {1'b0, den_i}) begin
        sh  = sh - {1'b0, den_i};
        quo = {quo[NUM_W-2:0], 1'b1};
      end else begin
        quo = {quo[NUM_W-2:0], 1'b0};
      end
      rem = sh[31:0];
    end
    lane_o.rem = rem;
    lane_o.num = num;
    lane_o.quo = quo;
  end

endmodule

// File: rtl/homogeneous_point_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed-point vertex transform with perspective divide by w.
//
//   channel  | dir | beat contents
//   in_bus   | in  | command, x_in, y_in, z_in
//   out_bus  | out | x_out, y_out, z_out, divided, saturated
//   cfg_bus  | in  | index, data (one 64-bit matrix register)
//
// Accepts one beat per clock while the output is not stalled; the pipelined
// restoring divider retires 4 quotient bits a stage (DIV_STAGES stages at Q16.16).
// Stages: multiply, sum, reduce, divider setup, divider, output register.
// Each stage holds while the one after it is full and stalled; bubbles close.
// Synchronous reset clears valid bits and restores the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform
  import hpt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  hpt_in_if.sink    in_bus,
  hpt_out_if.source out_bus,
  hpt_cfg_if.sink   cfg_bus
);

  localparam int DS = DIV_STAGES;

  // Matrix registers
  logic [63:0] cfg_r [CFG_REGS];

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= 64'(ONE_FX);
      cfg_r[1] <= 64'h0;
      cfg_r[2] <= {ONE_FX, 32'h0};
      cfg_r[3] <= 64'h0;
      cfg_r[4] <= 64'h0;
      cfg_r[5] <= 64'(ONE_FX);
      cfg_r[6] <= 64'h0;
      cfg_r[7] <= {ONE_FX, 32'h0};
    end else if (cfg_bus.valid) begin
      cfg_r[cfg_bus.index] <= cfg_bus.data;
    end
  end

  logic signed [31:0] mtx [4][4];
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mtx[r][c] = cfg_r[2*r + c/2][32*(c%2) +: 32];
    end
  end

  // Handshake chain
  logic          o_rdy;
  logic [DS:0]   d_rdy;
  logic          s1_rdy, s2_rdy, s3_rdy;
  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [DS:0]   dv_r;
  logic          out_v_r;

  assign o_rdy     = !out_v_r || out_bus.ready;
  assign d_rdy[DS] = !dv_r[DS] || o_rdy;
  for (genvar k = 0; k < DS; k++) begin : g_rdy
    assign d_rdy[k] = !dv_r[k] || d_rdy[k+1];
  end
  assign s3_rdy = !s3_v_r || d_rdy[0];
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_bus.ready = s1_rdy;

  // Stage 1: products
  logic signed [31:0] vin [3];
  logic signed [63:0] s1_prod_r  [4][3];
  logic signed [63:0] s1_trans_r [4];
  logic               s1_point_r;

  assign vin[0] = in_bus.x_in;
  assign vin[1] = in_bus.y_in;
  assign vin[2] = in_bus.z_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_bus.valid) begin
      s1_point_r <= (cmd_t'(in_bus.command) == CMD_POINT);
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod_r[r][c] <= mtx[r][c] * vin[c];
        end
        s1_trans_r[r] <= (cmd_t'(in_bus.command) == CMD_POINT)
                         ? (64'(mtx[r][3]) <<< FRAC_BITS) : 64'sd0;
      end
    end
  end

  // Stage 2: row sums
  logic signed [ACC_W-1:0] s2_acc_r [4];
  logic                    s2_point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_point_r <= s1_point_r;
      for (int r = 0; r < 4; r++) begin
        s2_acc_r[r] <= ACC_W'(s1_prod_r[r][0]) + ACC_W'(s1_prod_r[r][1])
                     + ACC_W'(s1_prod_r[r][2]) + ACC_W'(s1_trans_r[r]);
      end
    end
  end

  // Stage 3: truncate and clamp
  logic [32:0]        red [4];
  logic signed [31:0] s3_res_r [4];
  logic               s3_sat_r, s3_wsat_r, s3_point_r;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      red[r] = reduce_acc(s2_acc_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_point_r <= s2_point_r;
      s3_sat_r   <= red[0][32] | red[1][32] | red[2][32];
      s3_wsat_r  <= red[3][32];
      for (int r = 0; r < 4; r++) begin
        s3_res_r[r] <= red[r][31:0];
      end
    end
  end

  // Divider setup: magnitudes, signs, divide decision
  dstg_t dp_r [DS+1];
  dstg_t setup_nxt;
  logic  do_div;

  always_comb begin
    logic [31:0] mag;
    do_div = s3_point_r && (s3_res_r[3] != 32'sd0) && (s3_res_r[3] != $signed(ONE_FX));
    setup_nxt.div = do_div;
    setup_nxt.sat = s3_sat_r | (do_div & s3_wsat_r);
    setup_nxt.den = s3_res_r[3][31] ? (~s3_res_r[3] + 32'd1) : s3_res_r[3];
    for (int i = 0; i < 3; i++) begin
      mag = s3_res_r[i][31] ? (~s3_res_r[i] + 32'd1) : s3_res_r[i];
      setup_nxt.neg[i]      = s3_res_r[i][31] ^ s3_res_r[3][31];
      setup_nxt.res[i]      = s3_res_r[i];
      setup_nxt.lane[i].rem = 32'h0;
      setup_nxt.lane[i].num = NUM_W'(mag) << FRAC_BITS;
      setup_nxt.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (d_rdy[0]) begin
      dv_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy[0] && s3_v_r) begin
      dp_r[0] <= setup_nxt;
    end
  end

  // Divider pipeline
  for (genvar k = 0; k < DS; k++) begin : g_div
    lane_t step_out [3];
    dstg_t stg_nxt;

    for (genvar i = 0; i < 3; i++) begin : g_lane
      hpt_div_step u_step (
        .lane_i (dp_r[k].lane[i]),
        .den_i  (dp_r[k].den),
        .lane_o (step_out[i])
      );
    end

    always_comb begin
      stg_nxt = dp_r[k];
      for (int i = 0; i < 3; i++) begin
        stg_nxt.lane[i] = step_out[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (d_rdy[k+1]) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (d_rdy[k+1] && dv_r[k]) begin
        dp_r[k+1] <= stg_nxt;
      end
    end
  end

  // Output: sign, clamp quotient, select
  logic [31:0] fin_val [3];
  logic [2:0]  fin_qsat;
  logic [31:0] out_res_r [3];
  logic        out_div_r, out_sat_r;

  always_comb begin
    logic [NUM_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = dp_r[DS].lane[i].quo;
      if (!dp_r[DS].neg[i]) begin
        fin_qsat[i] = q > NUM_W'(32'h7FFF_FFFF);
        fin_val[i]  = fin_qsat[i] ? 32'h7FFF_FFFF : q[31:0];
      end else begin
        fin_qsat[i] = q > NUM_W'(32'h8000_0000);
        fin_val[i]  = fin_qsat[i] ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end
      if (!dp_r[DS].div) begin
        fin_val[i] = dp_r[DS].res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_rdy) begin
      out_v_r <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && dv_r[DS]) begin
      out_div_r <= dp_r[DS].div;
      out_sat_r <= dp_r[DS].sat | (dp_r[DS].div & (|fin_qsat));
      for (int i = 0; i < 3; i++) begin
        out_res_r[i] <= fin_val[i];
      end
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.x_out     = out_res_r[0];
  assign out_bus.y_out     = out_res_r[1];
  assign out_bus.z_out     = out_res_r[2];
  assign out_bus.divided   = out_div_r;
  assign out_bus.saturated = out_sat_r;

  // Checks
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] && dp_r[0].div |-> dp_r[0].den != 32'h0)
    else $error("divide issued with zero divisor");

  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DS] && !d_rdy[DS] |=> dv_r[DS])
    else $error("stalled divider stage dropped its item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !dv_r[0] && !s1_v_r)
    else $error("pipeline not empty after reset");

endmodule
